/* design/sequential_element_evaluator_unit_defines.svh */
// ----------------------------------------------------------------------------
// Sequential element evaluator: assertion macros
// Concurrent check helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_ELEMENT_EVALUATOR_UNIT_DEFINES_SVH
`define SEQUENTIAL_ELEMENT_EVALUATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define SEU_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("seu check failed");

// expression that must never be true outside reset
`define SEU_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("seu forbidden condition");

`else

`define SEU_ASSERT_RST(lbl, clk, rstn, prop)

`define SEU_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

/* design/seu_pkg.sv */
// ----------------------------------------------------------------------------
// seu_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package seu_pkg;

    // store geometry
    localparam int ELEMENT_COUNT = 1024;
    localparam int STATE_BITS    = 10;
    localparam int ADDR_W        = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

    // word field widths
    localparam int ID_W   = 10;
    localparam int TYPE_W = 3;
    localparam int IN_W   = 11;
    localparam int CNT_W  = 4;
    localparam int OUT_W  = 10;
    localparam int ERR_W  = 2;

    // element types
    localparam logic [TYPE_W-1:0] TYPE_BUTTON    = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_CLOCK_GEN = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_JK        = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_SHIFT_REG = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_LATCH_D   = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_FF_D      = 3'd5;
    localparam logic [TYPE_W-1:0] TYPE_MS_D      = 3'd6;
    localparam logic [TYPE_W-1:0] TYPE_STATELESS = 3'd7;

    // result error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_SIZE      = 2'd1;
    localparam logic [ERR_W-1:0] ERR_STATELESS = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } seu_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear_wr;   // write zero at clear pointer, advance it
        logic accept;     // capture input word, start store read
        logic commit;     // write back state, load output register
    } seu_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last; // clear pointer at last entry
        logic out_full;   // output register holds an untaken word
    } seu_status_t;

endpackage

/* design/seu_ctrl.sv */
// ----------------------------------------------------------------------------
// seu_ctrl
// Controller FSM: clearing pass, input accept, update and commit sequencing.
// ----------------------------------------------------------------------------
`include "sequential_element_evaluator_unit_defines.svh"

module seu_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 m_ready,
    input  seu_pkg::seu_status_t status,
    output seu_pkg::seu_cmd_t    cmd
);
    import seu_pkg::*;

    seu_state_t state_reg;
    seu_state_t state_next;
    logic       out_free;

    // output register is free now or is being emptied this cycle
    assign out_free = !status.out_full || m_ready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = 1'b0;
        cmd.clear_wr = 1'b0;
        cmd.accept   = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_UPDATE: begin
                cmd.commit = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // checks
    `SEU_ASSERT_NEVER(a_accept_commit_overlap, aclk, aresetn, cmd.accept && cmd.commit)
    `SEU_ASSERT_RST(a_accept_to_update, aclk, aresetn, cmd.accept |=> state_reg == ST_UPDATE)
    `SEU_ASSERT_RST(a_commit_fills_out, aclk, aresetn, cmd.commit |=> status.out_full)
    `SEU_ASSERT_RST(a_stall_holds, aclk, aresetn, (state_reg == ST_UPDATE && status.out_full && !m_ready) |=> state_reg == ST_UPDATE)
    `SEU_ASSERT_RST(a_clear_ends, aclk, aresetn, (cmd.clear_wr && status.clear_last) |=> state_reg == ST_IDLE)

endmodule

/* design/seu_datapath.sv */
// ----------------------------------------------------------------------------
// seu_datapath
// State store, input capture, element update logic and output register.
// ----------------------------------------------------------------------------
module seu_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  seu_pkg::seu_cmd_t            cmd,
    output seu_pkg::seu_status_t         status,
    input  logic [seu_pkg::ID_W-1:0]     s_element_id,
    input  logic [seu_pkg::TYPE_W-1:0]   s_req_type,
    input  logic [seu_pkg::IN_W-1:0]     s_old_inputs,
    input  logic [seu_pkg::IN_W-1:0]     s_new_inputs,
    input  logic [seu_pkg::CNT_W-1:0]    s_input_count,
    input  logic [seu_pkg::CNT_W-1:0]    s_output_count,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [seu_pkg::ID_W-1:0]     m_element_id_out,
    output logic [seu_pkg::OUT_W-1:0]    m_output_bits,
    output logic [seu_pkg::ERR_W-1:0]    m_error_code
);
    import seu_pkg::*;

    localparam int SHW = $clog2(STATE_BITS + 1);

    // inputs each type needs at minimum
    function automatic logic [CNT_W-1:0] inputs_needed(input logic [TYPE_W-1:0] ty);
        logic [CNT_W-1:0] r;
        r = '0;
        case (ty)
            TYPE_BUTTON:    r = 4'd0;
            TYPE_CLOCK_GEN: r = 4'd3;
            TYPE_JK:        r = 4'd5;
            TYPE_SHIFT_REG: r = 4'd1;
            TYPE_LATCH_D:   r = 4'd2;
            TYPE_FF_D:      r = 4'd4;
            TYPE_MS_D:      r = 4'd4;
            default:        r = 4'd0;
        endcase
        return r;
    endfunction

    // state store
    logic [STATE_BITS-1:0] mem [ELEMENT_COUNT];
    logic [STATE_BITS-1:0] rd_data_reg;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [STATE_BITS-1:0] wr_data;

    // clear pointer
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;

    // captured item
    logic [ID_W-1:0]   id_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [IN_W-1:0]   old_reg;
    logic [IN_W-1:0]   new_reg;
    logic [CNT_W-1:0]  icnt_reg;
    logic [CNT_W-1:0]  ocnt_reg;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [OUT_W-1:0]  out_bits_reg;
    logic [ERR_W-1:0]  out_err_reg;

    // update results
    logic [STATE_BITS-1:0] s_new;
    logic [OUT_W-1:0]      o_new;
    logic [ERR_W-1:0]      err;

    // clear pointer
    assign clr_cnt_next = cmd.clear_wr ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign status.clear_last = (clr_cnt_reg == ADDR_W'(ELEMENT_COUNT - 1));

    // store write port: clearing pass or write back
    assign wr_en   = cmd.clear_wr || (cmd.commit && err == ERR_NONE);
    assign wr_addr = cmd.clear_wr ? clr_cnt_reg : ADDR_W'(id_reg);
    assign wr_data = cmd.clear_wr ? '0 : s_new;

    // store read port, registered, addressed by the incoming word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.accept) begin
            rd_data_reg <= mem[ADDR_W'(s_element_id)];
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            id_reg   <= s_element_id;
            type_reg <= s_req_type;
            old_reg  <= s_old_inputs;
            new_reg  <= s_new_inputs;
            icnt_reg <= s_input_count;
            ocnt_reg <= s_output_count;
        end
    end

    // element update
    always_comb begin
        logic                  rise;
        logic                  fall;
        logic [CNT_W-1:0]      n;
        logic [STATE_BITS-1:0] lm;
        logic [STATE_BITS-1:0] om;
        logic [STATE_BITS-1:0] s;
        logic [STATE_BITS-1:0] o;
        logic [SHW-1:0]        osh;

        rise = new_reg[0] && !old_reg[0];
        fall = !new_reg[0] && old_reg[0];
        n    = icnt_reg - 1'b1;
        lm   = (int'(n) >= STATE_BITS) ? '1 : ~({STATE_BITS{1'b1}} << n);
        om   = (int'(ocnt_reg) >= STATE_BITS) ? '1 : ~({STATE_BITS{1'b1}} << ocnt_reg);
        osh  = SHW'(STATE_BITS) - SHW'(ocnt_reg);
        s    = rd_data_reg;
        o    = '0;
        err  = ERR_NONE;

        // error checks, stateless first
        if (type_reg == TYPE_STATELESS) begin
            err = ERR_STATELESS;
        end else if (int'(id_reg) >= ELEMENT_COUNT || icnt_reg < inputs_needed(type_reg)) begin
            err = ERR_SIZE;
        end else if (type_reg == TYPE_SHIFT_REG &&
                     (int'(n) > STATE_BITS || int'(ocnt_reg) > STATE_BITS)) begin
            err = ERR_SIZE;
        end

        case (type_reg)
            TYPE_BUTTON: begin
                o[0] = s[0];
            end
            TYPE_CLOCK_GEN: begin
                // bit0 enabled, bit1 output, bit2/3 loop toggles
                if (!s[0]) begin
                    if (new_reg[0]) begin
                        s[1:0] = 2'b11;
                        s[2]   = ~s[2];
                    end
                end else if (new_reg[1] ^ old_reg[1]) begin
                    s[1] = 1'b0;
                    s[3] = ~s[3];
                end else if (new_reg[2] ^ old_reg[2]) begin
                    if (new_reg[0]) begin
                        s[1] = 1'b1;
                        s[2] = ~s[2];
                    end else begin
                        s[0] = 1'b0;
                    end
                end
                o[2:0] = s[3:1];
            end
            TYPE_JK: begin
                // reset wins over set; master on rise, slave on fall
                if (new_reg[4]) begin
                    s[1:0] = 2'b00;
                end else if (new_reg[3]) begin
                    s[1:0] = 2'b11;
                end else if (rise) begin
                    if (new_reg[1] && new_reg[2]) s[0] = ~s[1];
                    else if (new_reg[1])          s[0] = 1'b1;
                    else if (new_reg[2])          s[0] = 1'b0;
                end else if (fall) begin
                    s[1] = s[0];
                end
                o[0] = s[1];
                o[1] = ~s[1];
            end
            TYPE_SHIFT_REG: begin
                // load on rise, shift up by data count on fall
                if (rise) begin
                    s = (s & ~lm) | (STATE_BITS'(new_reg[IN_W-1:1]) & lm);
                end
                if (fall && int'(n) < STATE_BITS) begin
                    s = (s & lm) | (s << n);
                end
                if (ocnt_reg != '0) begin
                    o = (s >> osh) & om;
                end
            end
            TYPE_LATCH_D: begin
                if (new_reg[0]) s[0] = new_reg[1];
                o[0] = s[0];
            end
            TYPE_FF_D: begin
                if (new_reg[3])      s[0] = 1'b0;
                else if (new_reg[2]) s[0] = 1'b1;
                else if (rise)       s[0] = new_reg[1];
                o[0] = s[0];
            end
            default: begin
                // master-slave D
                if (new_reg[3])      s[1:0] = 2'b00;
                else if (new_reg[2]) s[1:0] = 2'b11;
                else if (rise)       s[0] = new_reg[1];
                else if (fall)       s[1] = s[0];
                o[0] = s[1];
            end
        endcase

        s_new = s;
        o_new = (err == ERR_NONE) ? OUT_W'(o) : '0;
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)   out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_id_reg   <= id_reg;
            out_bits_reg <= o_new;
            out_err_reg  <= err;
        end
    end

    assign status.out_full = out_valid_reg;
    assign m_valid          = out_valid_reg;
    assign m_element_id_out = out_id_reg;
    assign m_output_bits    = out_bits_reg;
    assign m_error_code     = out_err_reg;

endmodule

/* design/sequential_element_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// sequential_element_evaluator_unit
// Evaluates one stateful simulation element per word against its stored state.
// ----------------------------------------------------------------------------
//  channel | ports                                             | role
//  --------+---------------------------------------------------+--------------
//  s_      | s_valid s_ready s_element_id .. s_output_count    | request word
//  m_      | m_valid m_ready m_element_id_out .. m_error_code  | result word
//
//  Each word: store read at accept, then update and write back in the update state.
//  The store read is registered; a word waits in update only
//  while the output register is full and m_ready is low.
//  After reset a clearing pass zeroes the store, with s_ready low.
//  A new word is accepted while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module sequential_element_evaluator_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [seu_pkg::ID_W-1:0]     s_element_id,
    input  logic [seu_pkg::TYPE_W-1:0]   s_req_type,
    input  logic [seu_pkg::IN_W-1:0]     s_old_inputs,
    input  logic [seu_pkg::IN_W-1:0]     s_new_inputs,
    input  logic [seu_pkg::CNT_W-1:0]    s_input_count,
    input  logic [seu_pkg::CNT_W-1:0]    s_output_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [seu_pkg::ID_W-1:0]     m_element_id_out,
    output logic [seu_pkg::OUT_W-1:0]    m_output_bits,
    output logic [seu_pkg::ERR_W-1:0]    m_error_code
);
    import seu_pkg::*;

    seu_cmd_t    cmd;
    seu_status_t status;

    // sequencing
    seu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // store and update logic
    seu_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_element_id     (s_element_id),
        .s_req_type       (s_req_type),
        .s_old_inputs     (s_old_inputs),
        .s_new_inputs     (s_new_inputs),
        .s_input_count    (s_input_count),
        .s_output_count   (s_output_count),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_element_id_out (m_element_id_out),
        .m_output_bits    (m_output_bits),
        .m_error_code     (m_error_code)
    );

endmodule

/* tb/sv/sequential_element_evaluator_unit_tb.sv */
// ----------------------------------------------------------------------------
// sequential_element_evaluator_unit_tb
// Self-checking bench for the sequential element evaluator. A queue of request
// words (directed corner cases, then random edge sequences per element) feeds
// a clocked driver; each accepted word is evaluated by a local model of the
// state store and the expected result is queued for the clocked monitor.
// ----------------------------------------------------------------------------
module sequential_element_evaluator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import seu_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 1925;
    localparam int IDLE_PCT     = 38;
    localparam int HOLD_AT      = 600;   // results seen before the long m_ready hold
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_FROM   = 1100;  // no idling on either side in this result span
    localparam int QUIET_TO     = 1400;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TYPE_W-1:0] kind;
        logic [IN_W-1:0]   old_in;
        logic [IN_W-1:0]   new_in;
        logic [CNT_W-1:0]  in_cnt;
        logic [CNT_W-1:0]  out_cnt;
    } request_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [OUT_W-1:0] bits;
        logic [ERR_W-1:0] err;
    } result_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [ID_W-1:0]     s_element_id   = '0;
    logic [TYPE_W-1:0]   s_req_type     = TYPE_BUTTON;
    logic [IN_W-1:0]     s_old_inputs   = '0;
    logic [IN_W-1:0]     s_new_inputs   = '0;
    logic [CNT_W-1:0]    s_input_count  = '0;
    logic [CNT_W-1:0]    s_output_count = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [ID_W-1:0]     m_element_id_out;
    logic [OUT_W-1:0]    m_output_bits;
    logic [ERR_W-1:0]    m_error_code;

    // model state and bench bookkeeping
    logic [STATE_BITS-1:0] element_bits [ELEMENT_COUNT];
    logic [IN_W-1:0]       last_inputs  [ELEMENT_COUNT];
    request_t              pending_words[$];
    result_t               expected_results[$];
    request_t              active_word;
    result_t               seen_word;
    result_t               due_word;
    int                    results_seen = 0;
    int                    fail_count   = 0;
    int                    cycle_count  = 0;
    int                    hold_left    = 0;
    logic                  hold_done    = 1'b0;
    logic                  quiet_window;

    assign quiet_window = (results_seen >= QUIET_FROM) && (results_seen < QUIET_TO);

    sequential_element_evaluator_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_element_id     (s_element_id),
        .s_req_type       (s_req_type),
        .s_old_inputs     (s_old_inputs),
        .s_new_inputs     (s_new_inputs),
        .s_input_count    (s_input_count),
        .s_output_count   (s_output_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_element_id_out (m_element_id_out),
        .m_output_bits    (m_output_bits),
        .m_error_code     (m_error_code)
    );

    always #5 aclk = ~aclk;

    // minimum input connections per element type
    function automatic int inputs_needed(logic [TYPE_W-1:0] kind);
        case (kind)
            TYPE_CLOCK_GEN:      return 3;
            TYPE_JK:             return 5;
            TYPE_SHIFT_REG:      return 1;
            TYPE_LATCH_D:        return 2;
            TYPE_FF_D, TYPE_MS_D: return 4;
            default:             return 0;
        endcase
    endfunction

    // evaluate one element against the model store and write its state back
    function automatic result_t evaluate_element(request_t r);
        result_t               res;
        logic [STATE_BITS-1:0] s;
        logic [STATE_BITS-1:0] keep_mask;
        logic [IN_W-1:0]       diff;
        logic                  rise;
        logic                  fall;
        int                    shift_n;
        res.id   = r.id;
        res.bits = '0;
        res.err  = ERR_NONE;
        if (r.kind == TYPE_STATELESS) begin
            res.err = ERR_STATELESS;
            return res;
        end
        if (int'(r.id) >= ELEMENT_COUNT || int'(r.in_cnt) < inputs_needed(r.kind)) begin
            res.err = ERR_SIZE;
            return res;
        end
        if (r.kind == TYPE_SHIFT_REG &&
            (int'(r.in_cnt) - 1 > STATE_BITS || int'(r.out_cnt) > STATE_BITS)) begin
            res.err = ERR_SIZE;
            return res;
        end
        s    = element_bits[r.id];
        rise = r.new_in[0] & ~r.old_in[0];
        fall = ~r.new_in[0] & r.old_in[0];
        diff = r.new_in ^ r.old_in;
        case (r.kind)
            TYPE_BUTTON: begin
                res.bits = OUT_W'(s[0]);
            end
            TYPE_CLOCK_GEN: begin
                // bit0 enabled, bit1 output, bit2/bit3 loop toggles
                if (!s[0]) begin
                    if (r.new_in[0]) begin
                        s[1:0] = 2'b11;
                        s[2]   = ~s[2];
                    end
                end else if (diff[1]) begin
                    s[1] = 1'b0;
                    s[3] = ~s[3];
                end else if (diff[2]) begin
                    if (r.new_in[0]) begin
                        s[1] = 1'b1;
                        s[2] = ~s[2];
                    end else begin
                        s[0] = 1'b0;
                    end
                end
                res.bits = OUT_W'(s[3:1]);
            end
            TYPE_JK: begin
                if (r.new_in[4]) s[1:0] = 2'b00;
                else if (r.new_in[3]) s[1:0] = 2'b11;
                else if (rise) begin
                    if (r.new_in[1] && r.new_in[2]) s[0] = ~s[1];
                    else if (r.new_in[1]) s[0] = 1'b1;
                    else if (r.new_in[2]) s[0] = 1'b0;
                end else if (fall) s[1] = s[0];
                res.bits = OUT_W'({~s[1], s[1]});
            end
            TYPE_SHIFT_REG: begin
                shift_n   = int'(r.in_cnt) - 1;
                keep_mask = STATE_BITS'((1 << shift_n) - 1);
                if (rise) s = (s & ~keep_mask) | (STATE_BITS'(r.new_in >> 1) & keep_mask);
                if (fall && shift_n < STATE_BITS) s = (s & keep_mask) | (s << shift_n);
                if (r.out_cnt != 0)
                    res.bits = OUT_W'((s >> (STATE_BITS - int'(r.out_cnt)))
                                      & STATE_BITS'((1 << int'(r.out_cnt)) - 1));
            end
            TYPE_LATCH_D: begin
                if (r.new_in[0]) s[0] = r.new_in[1];
                res.bits = OUT_W'(s[0]);
            end
            TYPE_FF_D: begin
                if (r.new_in[3]) s[0] = 1'b0;
                else if (r.new_in[2]) s[0] = 1'b1;
                else if (rise) s[0] = r.new_in[1];
                res.bits = OUT_W'(s[0]);
            end
            default: begin
                // master-slave D: master on rise, slave on fall
                if (r.new_in[3]) s[1:0] = 2'b00;
                else if (r.new_in[2]) s[1:0] = 2'b11;
                else if (rise) s[0] = r.new_in[1];
                else if (fall) s[1] = s[0];
                res.bits = OUT_W'(s[1]);
            end
        endcase
        element_bits[r.id] = s;
        return res;
    endfunction

    task automatic queue_request(input logic [ID_W-1:0] id, input logic [TYPE_W-1:0] kind,
                                 input logic [IN_W-1:0] old_in, input logic [IN_W-1:0] new_in,
                                 input logic [CNT_W-1:0] in_cnt,
                                 input logic [CNT_W-1:0] out_cnt);
        request_t r;
        r = '{id, kind, old_in, new_in, in_cnt, out_cnt};
        last_inputs[id] = new_in;
        pending_words.push_back(r);
    endtask

    // mostly clean edge sequences on a few hot elements, some noise
    task automatic queue_random_request();
        logic [ID_W-1:0]   id;
        logic [TYPE_W-1:0] kind;
        logic [IN_W-1:0]   old_in;
        logic [IN_W-1:0]   new_in;
        logic [CNT_W-1:0]  in_cnt;
        logic [CNT_W-1:0]  out_cnt;
        int                pick;
        int                floor_cnt;
        pick = $urandom_range(99);
        if (pick < 70) id = ID_W'($urandom_range(15));
        else if (pick < 95) id = ID_W'($urandom);
        else id = ($urandom_range(1) != 0) ? '1 : '0;
        kind = ($urandom_range(99) < 8) ? TYPE_STATELESS : TYPE_W'($urandom_range(6));
        floor_cnt = (inputs_needed(kind) < 1) ? 1 : inputs_needed(kind);
        if ($urandom_range(99) < 10) in_cnt = CNT_W'($urandom);
        else in_cnt = CNT_W'($urandom_range(11, floor_cnt));
        if ($urandom_range(99) < 10) out_cnt = CNT_W'($urandom);
        else out_cnt = CNT_W'($urandom_range(10, 1));
        if ($urandom_range(99) < 15) begin
            old_in = IN_W'($urandom);
            new_in = IN_W'($urandom);
        end else begin
            old_in    = last_inputs[id];
            new_in    = IN_W'($urandom);
            new_in[0] = ($urandom_range(1) != 0) ? ~old_in[0] : old_in[0];
            // keep async set/reset quiet most of the time
            if ($urandom_range(99) < 80) begin
                case (kind)
                    TYPE_JK:              new_in[4:3] = 2'b00;
                    TYPE_FF_D, TYPE_MS_D: new_in[3:2] = 2'b00;
                    default: ;
                endcase
            end
        end
        queue_request(id, kind, old_in, new_in, in_cnt, out_cnt);
    endtask

    task automatic note_failure(input string what, input result_t want, input result_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected id=%0d bits=%h err=%0d, got id=%0d bits=%h err=%0d",
                     $time, what, want.id, want.bits, want.err, got.id, got.bits, got.err);
    endtask

    // request driver: predicts on accept, then offers the next word or idles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) expected_results.push_back(evaluate_element(active_word));
            if (pending_words.size() != 0 &&
                (quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
                active_word     = pending_words.pop_front();
                s_element_id   <= active_word.id;
                s_req_type     <= active_word.kind;
                s_old_inputs   <= active_word.old_in;
                s_new_inputs   <= active_word.new_in;
                s_input_count  <= active_word.in_cnt;
                s_output_count <= active_word.out_cnt;
                s_valid        <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus one long hold to back up the block
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= quiet_window || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result monitor: in-order compare against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            seen_word = '{m_element_id_out, m_output_bits, m_error_code};
            if (expected_results.size() == 0) begin
                note_failure("unexpected word", '0, seen_word);
            end else begin
                due_word = expected_results.pop_front();
                if (seen_word.id !== due_word.id || seen_word.bits !== due_word.bits ||
                    seen_word.err !== due_word.err)
                    note_failure("mismatch", due_word, seen_word);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[sequential_element_evaluator_unit] ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < ELEMENT_COUNT; i++) begin
            element_bits[i] = '0;
            last_inputs[i]  = '0;
        end

        // directed corner cases
        queue_request(0, TYPE_STATELESS, 11'h000, 11'h000, 4'd11, 4'd10);
        queue_request(0, TYPE_BUTTON, 11'h000, 11'h000, 4'd0, 4'd0);
        queue_request(1, TYPE_CLOCK_GEN, 11'h000, 11'h001, 4'd2, 4'd1);     // too few inputs
        queue_request(1, TYPE_CLOCK_GEN, 11'h000, 11'h001, 4'd3, 4'd1);     // enable
        queue_request(1, TYPE_CLOCK_GEN, 11'h001, 11'h003, 4'd3, 4'd1);     // on loop done
        queue_request(1, TYPE_CLOCK_GEN, 11'h003, 11'h007, 4'd3, 4'd1);     // off loop, enabled
        queue_request(1, TYPE_CLOCK_GEN, 11'h004, 11'h000, 4'd3, 4'd1);     // off loop, disable
        queue_request(2, TYPE_JK, 11'h000, 11'h001, 4'd4, 4'd1);            // too few inputs
        queue_request(2, TYPE_JK, 11'h000, 11'h008, 4'd5, 4'd1);            // set
        queue_request(2, TYPE_JK, 11'h008, 11'h018, 4'd5, 4'd1);            // reset beats set
        queue_request(2, TYPE_JK, 11'h000, 11'h007, 4'd5, 4'd1);            // J and K toggle
        queue_request(2, TYPE_JK, 11'h007, 11'h000, 4'd5, 4'd1);            // falling edge
        queue_request(3, TYPE_SHIFT_REG, 11'h000, 11'h000, 4'd12, 4'd1);    // inputs too wide
        queue_request(3, TYPE_SHIFT_REG, 11'h000, 11'h000, 4'd4, 4'd11);    // outputs too wide
        queue_request(3, TYPE_SHIFT_REG, 11'h000, 11'h7FF, 4'd11, 4'd10);   // full load
        queue_request(3, TYPE_SHIFT_REG, 11'h7FF, 11'h7FE, 4'd11, 4'd10);   // shift by width
        queue_request(3, TYPE_SHIFT_REG, 11'h000, 11'h00B, 4'd4, 4'd4);     // partial load
        queue_request(3, TYPE_SHIFT_REG, 11'h00B, 11'h00A, 4'd4, 4'd0);     // shift, no outputs
        queue_request(3, TYPE_SHIFT_REG, 11'h001, 11'h000, 4'd15, 4'd15);
        queue_request(4, TYPE_LATCH_D, 11'h000, 11'h003, 4'd1, 4'd1);       // too few inputs
        queue_request(4, TYPE_LATCH_D, 11'h000, 11'h003, 4'd2, 4'd1);       // transparent
        queue_request(5, TYPE_FF_D, 11'h000, 11'h003, 4'd4, 4'd1);          // capture on rise
        queue_request(5, TYPE_FF_D, 11'h003, 11'h00C, 4'd4, 4'd1);          // reset beats set
        queue_request(6, TYPE_MS_D, 11'h000, 11'h003, 4'd4, 4'd1);
        queue_request(6, TYPE_MS_D, 11'h003, 11'h000, 4'd4, 4'd1);
        queue_request(2, TYPE_BUTTON, 11'h7FF, 11'h7FF, 4'd15, 4'd15);      // type change
        queue_request(1023, TYPE_FF_D, 11'h000, 11'h7F7, 4'd15, 4'd15);

        for (int i = 0; i < RANDOM_WORDS; i++) queue_random_request();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("[sequential_element_evaluator_unit] OK");
        end else begin
            $display("[sequential_element_evaluator_unit] ERROR");
        end
        $finish;
    end

endmodule
